// ----- src/life_grid_generation_step_unit_assert.svh -----
// Assertion macros for the life grid generation step unit.
// Included by the top level; no other dependencies.
`ifndef LIFE_GRID_GENERATION_STEP_UNIT_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LGS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lgs_pkg.sv -----
// Shared constants and types for the life grid generation step unit.
// No dependencies.
package lgs_pkg;

    localparam int GRID_DIM = 8;
    localparam int ROW_W    = $clog2(GRID_DIM);

    typedef logic [GRID_DIM-1:0] row_t;
    typedef logic [ROW_W-1:0]    row_idx_t;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_RD,
        ST_PRIME,
        ST_ADV,
        ST_FIN
    } state_t;

    localparam logic [3:0] SURVIVE_LO = 4'd2;
    localparam logic [3:0] BIRTH_CNT  = 4'd3;

endpackage

// ----- src/lgs_row_update.sv -----
// Next generation of one grid row from the row above, itself and the row below.
// Depends on lgs_pkg.
module lgs_row_update (
    input  lgs_pkg::row_t above_row,
    input  lgs_pkg::row_t centre_row,
    input  lgs_pkg::row_t below_row,
    output lgs_pkg::row_t next_row
);

    // one dead cell on each side for the fixed edges
    logic [lgs_pkg::GRID_DIM+1:0] above_p;
    logic [lgs_pkg::GRID_DIM+1:0] centre_p;
    logic [lgs_pkg::GRID_DIM+1:0] below_p;

    assign above_p  = {1'b0, above_row, 1'b0};
    assign centre_p = {1'b0, centre_row, 1'b0};
    assign below_p  = {1'b0, below_row, 1'b0};

    always_comb begin
        logic [3:0] cnt;
        for (int c = 0; c < lgs_pkg::GRID_DIM; c++) begin
            cnt = 4'(above_p[c]) + 4'(above_p[c+1]) + 4'(above_p[c+2])
                + 4'(centre_p[c]) + 4'(centre_p[c+2])
                + 4'(below_p[c]) + 4'(below_p[c+1]) + 4'(below_p[c+2]);
            if (centre_row[c]) begin
                next_row[c] = (cnt == lgs_pkg::SURVIVE_LO) || (cnt == lgs_pkg::BIRTH_CNT);
            end else begin
                next_row[c] = (cnt == lgs_pkg::BIRTH_CNT);
            end
        end
    end

endmodule

// ----- src/life_grid_generation_step_unit.sv -----
// Life grid (B3/S23), grid held one row per word in a synchronous row memory.
// Items are taken one at a time: a new item is accepted only in the idle state, once the
// previous result is placed on the output; unused operation code 3 returns a zero result.
// Advance sweeps one row per cycle through the single read port, keeping the rows above
// and at the cell in a two-row window.
// Reset: row valid flops clear at once, so the grid reads dead with no clearing pass.
`include "life_grid_generation_step_unit_assert.svh"

module life_grid_generation_step_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation[1:0], row[4:2], column[7:5], cell_in[8], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // cell_out[0], zeros
);

    localparam int D = lgs_pkg::GRID_DIM;
    localparam int W = lgs_pkg::ROW_W;

    // row memory
    lgs_pkg::row_t mem [D];
    lgs_pkg::row_t rdata_reg;
    logic          rd_valid_reg;
    logic [D-1:0]  row_valid_reg;

    logic               rd_en;
    lgs_pkg::row_idx_t  rd_addr;
    logic               wr_en;
    lgs_pkg::row_idx_t  wr_addr;
    lgs_pkg::row_t      wr_data;

    lgs_pkg::state_t   state_reg, state_next;
    lgs_pkg::row_idx_t row_idx_reg, row_idx_next;
    lgs_pkg::row_idx_t col_idx_reg, col_idx_next;
    logic              cell_in_reg, cell_in_next;
    lgs_pkg::row_idx_t cnt_reg, cnt_next;
    lgs_pkg::row_t     above_reg, above_next;
    lgs_pkg::row_t     centre_reg, centre_next;
    logic              res_reg, res_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_data_reg, m_data_next;

    lgs_pkg::row_t rd_row;
    lgs_pkg::row_t below_row;
    lgs_pkg::row_t new_row;
    lgs_pkg::row_t rmw_row;
    logic          last_row;
    logic [W:0]    rd_ahead;

    lgs_pkg::op_t      in_op;
    lgs_pkg::row_idx_t in_row;
    lgs_pkg::row_idx_t in_col;
    logic              in_inside;

    assign in_op     = lgs_pkg::op_t'(s_tdata[1:0]);
    assign in_row    = W'(s_tdata[4:2]);
    assign in_col    = W'(s_tdata[7:5]);
    assign in_inside = (int'(s_tdata[4:2]) < D) && (int'(s_tdata[7:5]) < D);

    // a row never written reads as dead
    assign rd_row    = rd_valid_reg ? rdata_reg : '0;
    assign last_row  = (cnt_reg == W'(D - 1));
    assign below_row = last_row ? '0 : rd_row;
    assign rd_ahead  = {1'b0, cnt_reg} + (W + 1)'(2);

    lgs_row_update u_row_update (
        .above_row  (above_reg),
        .centre_row (centre_reg),
        .below_row  (below_row),
        .next_row   (new_row)
    );

    always_comb begin
        rmw_row = rd_row;
        rmw_row[col_idx_reg] = cell_in_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lgs_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_idx_reg <= row_idx_next;
        col_idx_reg <= col_idx_next;
        cell_in_reg <= cell_in_next;
        cnt_reg     <= cnt_next;
        above_reg   <= above_next;
        centre_reg  <= centre_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    // Accesses to one entry never overlap: an item starts only after the previous
    // one's write, and the sweep reads two rows ahead of the row it writes.
    always_comb begin
        state_next    = state_reg;
        row_idx_next  = row_idx_reg;
        col_idx_next  = col_idx_reg;
        cell_in_next  = cell_in_reg;
        cnt_next      = cnt_reg;
        above_next    = above_reg;
        centre_next   = centre_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        unique case (state_reg)
            lgs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    row_idx_next = in_row;
                    col_idx_next = in_col;
                    cell_in_next = s_tdata[8];
                    res_next     = 1'b0;
                    case (in_op)
                        lgs_pkg::OP_WRITE: begin
                            if (in_inside) begin
                                rd_en      = 1'b1;
                                rd_addr    = in_row;
                                state_next = lgs_pkg::ST_RMW;
                            end else begin
                                state_next = lgs_pkg::ST_FIN;
                            end
                        end
                        lgs_pkg::OP_READ: begin
                            if (in_inside) begin
                                rd_en      = 1'b1;
                                rd_addr    = in_row;
                                state_next = lgs_pkg::ST_RD;
                            end else begin
                                state_next = lgs_pkg::ST_FIN;
                            end
                        end
                        lgs_pkg::OP_ADVANCE: begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = lgs_pkg::ST_PRIME;
                        end
                        default: begin
                            state_next = lgs_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            lgs_pkg::ST_RMW: begin
                wr_en      = 1'b1;
                wr_addr    = row_idx_reg;
                wr_data    = rmw_row;
                state_next = lgs_pkg::ST_FIN;
            end
            lgs_pkg::ST_RD: begin
                res_next   = rd_row[col_idx_reg];
                state_next = lgs_pkg::ST_FIN;
            end
            lgs_pkg::ST_PRIME: begin
                above_next  = '0;
                centre_next = rd_row;
                cnt_next    = '0;
                rd_en       = 1'b1;
                rd_addr     = W'(1);
                state_next  = lgs_pkg::ST_ADV;
            end
            lgs_pkg::ST_ADV: begin
                wr_en       = 1'b1;
                wr_addr     = cnt_reg;
                wr_data     = new_row;
                above_next  = centre_reg;
                centre_next = below_row;
                if (last_row) begin
                    state_next = lgs_pkg::ST_FIN;
                end else begin
                    cnt_next = cnt_reg + W'(1);
                    if (int'(rd_ahead) < D) begin
                        rd_en   = 1'b1;
                        rd_addr = rd_ahead[W-1:0];
                    end
                end
            end
            lgs_pkg::ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_reg;
                    state_next    = lgs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lgs_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == lgs_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

    `LGS_ASSERT_IMPL(a_no_same_row, aclk, aresetn, wr_en && rd_en, wr_addr != rd_addr,
        "read and write hit the same row")
    `LGS_ASSERT_IMPL(a_wr_state, aclk, aresetn, wr_en,
        (state_reg == lgs_pkg::ST_RMW) || (state_reg == lgs_pkg::ST_ADV),
        "row write outside a write state")
    `LGS_ASSERT_NEXT(a_adv_walks, aclk, aresetn, (state_reg == lgs_pkg::ST_ADV) && !last_row,
        (state_reg == lgs_pkg::ST_ADV) && (cnt_reg == $past(cnt_reg) + W'(1)),
        "row sweep skipped a row")

endmodule

// ----- bench/life_grid_generation_step_unit_checker.sv -----
`timescale 1ns / 100ps
// Checker for the life grid unit: watches both streams, tracks its own copy of the grid
// and compares every returned item with the predicted cell value. Depends on lgs_pkg.
module life_grid_generation_step_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // operation[1:0], row[4:2], column[7:5], cell_in[8], zeros
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // cell_out[0], zeros
    output int          failures,
    output int          outstanding
);

    logic grid [lgs_pkg::GRID_DIM][lgs_pkg::GRID_DIM];
    logic cell_out_due [$];

    function automatic int live_neighbours(int r, int c);
        int n = 0;
        int rr, cc;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                // cells beyond the fixed edge count as dead
                if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0
                        && rr < lgs_pkg::GRID_DIM && cc < lgs_pkg::GRID_DIM)
                    n += int'(grid[rr][cc]);
            end
        end
        return n;
    endfunction

    task automatic step_generation();
        logic nxt [lgs_pkg::GRID_DIM][lgs_pkg::GRID_DIM];
        int n;
        for (int r = 0; r < lgs_pkg::GRID_DIM; r++) begin
            for (int c = 0; c < lgs_pkg::GRID_DIM; c++) begin
                n = live_neighbours(r, c);
                if (grid[r][c])
                    nxt[r][c] = (n == 2 || n == 3);
                else
                    nxt[r][c] = (n == 3);
            end
        end
        grid = nxt;
    endtask

    task automatic apply_item(input logic [15:0] item, output logic cell_out);
        logic [1:0]        op;
        lgs_pkg::row_idx_t row, col;
        logic              cell_in;
        bit                on_grid;
        op       = item[1:0];
        row      = item[4:2];
        col      = item[7:5];
        cell_in  = item[8];
        on_grid  = (int'(row) < lgs_pkg::GRID_DIM) && (int'(col) < lgs_pkg::GRID_DIM);
        cell_out = 1'b0;
        case (op)
            lgs_pkg::OP_WRITE: begin
                if (on_grid)
                    grid[row][col] = cell_in;
            end
            lgs_pkg::OP_ADVANCE: begin
                step_generation();
            end
            lgs_pkg::OP_READ: begin
                if (on_grid)
                    cell_out = grid[row][col];
            end
            default: ;   // unused code leaves the grid alone
        endcase
    endtask

    always @(posedge aclk) begin
        logic predicted;
        logic wanted;
        if (!aresetn) begin
            for (int r = 0; r < lgs_pkg::GRID_DIM; r++)
                for (int c = 0; c < lgs_pkg::GRID_DIM; c++)
                    grid[r][c] = 1'b0;
            cell_out_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (cell_out_due.size() == 0) begin
                    $display("%0t: result item with none expected, got cell_out %0d",
                             $time, m_tdata[0]);
                    failures++;
                end else begin
                    wanted = cell_out_due.pop_front();
                    if (m_tdata[0] !== wanted) begin
                        $display("%0t: cell_out mismatch, expected %0d, got %0d",
                                 $time, wanted, m_tdata[0]);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_item(s_tdata, predicted);
                cell_out_due.push_back(predicted);
            end
        end
        outstanding = cell_out_due.size();
    end

endmodule

// ----- bench/life_grid_generation_step_unit_tb.sv -----
`timescale 1ns / 100ps
// Top of the life grid unit testbench: clock, reset, directed and random stimulus, verdict.
// Depends on lgs_pkg, the unit itself and life_grid_generation_step_unit_checker.
module life_grid_generation_step_unit_tb;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 500;
    localparam int         DRAIN_CYCLES = 2 * (lgs_pkg::GRID_DIM + 3);
    localparam int         CYCLE_LIMIT  = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    int fail_count;
    int pending;
    int cycles;
    int items_sent;
    bit steady = 1'b0;

    life_grid_generation_step_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    life_grid_generation_step_unit_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (fail_count),
        .outstanding (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 23);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input lgs_pkg::row_idx_t row,
                             input lgs_pkg::row_idx_t col, input logic cell_in);
        while (!steady && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, cell_in, col, row, op};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    function automatic lgs_pkg::row_idx_t any_index();
        return lgs_pkg::row_idx_t'($urandom_range(0, lgs_pkg::GRID_DIM - 1));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    initial begin
        int pick;
        int base_r, base_c;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // corners, both write values, and an unused code that must not touch the grid
        send_item(lgs_pkg::OP_WRITE, 3'd0, 3'd0, 1'b1);
        send_item(lgs_pkg::OP_WRITE, 3'd7, 3'd7, 1'b1);
        send_item(lgs_pkg::OP_WRITE, 3'd0, 3'd7, 1'b1);
        send_item(lgs_pkg::OP_WRITE, 3'd7, 3'd0, 1'b1);
        send_item(lgs_pkg::OP_WRITE, 3'd7, 3'd0, 1'b0);
        send_item(lgs_pkg::OP_READ, 3'd0, 3'd0, 1'b1);
        send_item(lgs_pkg::OP_READ, 3'd7, 3'd7, 1'b0);
        send_item(lgs_pkg::OP_READ, 3'd0, 3'd7, 1'b0);
        send_item(lgs_pkg::OP_READ, 3'd7, 3'd0, 1'b1);
        send_item(OP_UNUSED, 3'd5, 3'd5, 1'b1);
        send_item(lgs_pkg::OP_READ, 3'd5, 3'd5, 1'b0);
        // blinker: flips between horizontal and vertical, lone corners die
        send_item(lgs_pkg::OP_WRITE, 3'd3, 3'd2, 1'b1);
        send_item(lgs_pkg::OP_WRITE, 3'd3, 3'd3, 1'b1);
        send_item(lgs_pkg::OP_WRITE, 3'd3, 3'd4, 1'b1);
        send_item(lgs_pkg::OP_ADVANCE, 3'd7, 3'd7, 1'b1);
        send_item(lgs_pkg::OP_READ, 3'd2, 3'd3, 1'b0);
        send_item(lgs_pkg::OP_READ, 3'd4, 3'd3, 1'b0);
        send_item(lgs_pkg::OP_READ, 3'd3, 3'd2, 1'b0);
        send_item(lgs_pkg::OP_READ, 3'd3, 3'd3, 1'b0);
        send_item(lgs_pkg::OP_READ, 3'd0, 3'd0, 1'b0);
        send_item(lgs_pkg::OP_ADVANCE, 3'd0, 3'd0, 1'b0);
        send_item(lgs_pkg::OP_READ, 3'd3, 3'd4, 1'b0);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            steady <= (items_sent >= 150 && items_sent < 280);
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // dense patch so that advances have something to work on
                base_r = $urandom_range(0, lgs_pkg::GRID_DIM - 4);
                base_c = $urandom_range(0, lgs_pkg::GRID_DIM - 4);
                repeat ($urandom_range(4, 10))
                    send_item(lgs_pkg::OP_WRITE,
                              lgs_pkg::row_idx_t'(base_r + $urandom_range(0, 3)),
                              lgs_pkg::row_idx_t'(base_c + $urandom_range(0, 3)),
                              $urandom_range(0, 9) < 7);
            end else if (pick < 45) begin
                repeat ($urandom_range(1, 3))
                    send_item(lgs_pkg::OP_ADVANCE, any_index(), any_index(), any_bit());
                repeat ($urandom_range(2, 6))
                    send_item(lgs_pkg::OP_READ, any_index(), any_index(), any_bit());
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    send_item(lgs_pkg::OP_WRITE, any_index(), any_index(), any_bit());
                else if (pick < 52)
                    send_item(lgs_pkg::OP_ADVANCE, any_index(), any_index(), any_bit());
                else if (pick < 92)
                    send_item(lgs_pkg::OP_READ, any_index(), any_index(), any_bit());
                else
                    send_item(OP_UNUSED, any_index(), any_index(), any_bit());
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/lgs_pkg.sv
src/lgs_row_update.sv
src/life_grid_generation_step_unit.sv
bench/life_grid_generation_step_unit_checker.sv
bench/life_grid_generation_step_unit_tb.sv
